@@ src/crast_pkg.sv @@
// ----------------------------------------------------------------------------
// Circle rasteriser package
// Shared widths, opcodes and controller command and status types.
// ----------------------------------------------------------------------------
package crast_pkg;

   localparam int RADIUS_BITS_DEFAULT = 10;

   localparam int OPCODE_W = 1;
   localparam int CENTER_W = 11;
   localparam int RADIUS_W = 10;
   localparam int COORD_W  = 13;

   localparam int POINTS  = 8;
   localparam int POINT_W = $clog2(POINTS);

   localparam logic [OPCODE_W-1:0] OP_START = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_STEP  = 1'b1;

   localparam int DEC_INIT     = 3;
   localparam int DEC_SCALE_SH = 2;
   localparam int DEC_INC_KEEP = 6;
   localparam int DEC_INC_DIAG = 10;

   typedef struct packed {
      logic load_start;
      logic load_step;
      logic next_point;
   } ctrl_cmd_type;

   typedef struct packed {
      logic active;
      logic point_last;
   } ctrl_status_type;

endpackage

@@ src/crast_if.sv @@
// ----------------------------------------------------------------------------
// Circle rasteriser channels
// Request and response handshake channels carrying valid, ready and payload.
// ----------------------------------------------------------------------------
interface crast_req_if
   import crast_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [CENTER_W-1:0] center_x;
   logic [CENTER_W-1:0] center_y;
   logic [RADIUS_W-1:0] radius;

   modport source (output valid, output opcode, output center_x, output center_y,
                   output radius, input ready);
   modport sink (input valid, input opcode, input center_x, input center_y,
                 input radius, output ready);
endinterface

interface crast_rsp_if
   import crast_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic                      last;
   logic                      done_res;

   modport source (output valid, output point_x, output point_y, output last,
                   output done_res, input ready);
   modport sink (input valid, input point_x, input point_y, input last,
                 input done_res, output ready);
endinterface

@@ src/crast_controller.sv @@
// ----------------------------------------------------------------------------
// Circle rasteriser controller
// Sequences item acceptance and the eight-point emission run.
// ----------------------------------------------------------------------------
module crast_controller
   import crast_pkg::*;
   (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [OPCODE_W-1:0] req_opcode,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  ctrl_status_type     status,
   output ctrl_cmd_type        cmd
   );

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      req_fire;
   logic      rsp_fire;
   logic      emits;

   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || (rsp_fire && status.point_last);
   assign req_fire  = req_valid && req_ready;
   assign emits     = req_fire && ((req_opcode == OP_START) || status.active);

   assign cmd.load_start = req_fire && (req_opcode == OP_START);
   assign cmd.load_step  = req_fire && (req_opcode == OP_STEP) && status.active;
   assign cmd.next_point = rsp_fire;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (emits) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_fire && status.point_last) begin
               state_in = emits ? ST_EMIT : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_emit_after_load: assert property (@(posedge clock) disable iff (reset)
      emits |=> (state_ff == ST_EMIT))
      else $error("Emitting item did not start an emission run.");

   a_idle_after_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && status.point_last && !emits) |=> (state_ff == ST_IDLE))
      else $error("Controller did not return to idle after the eighth point.");

   a_silent_step: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_opcode == OP_STEP) && !status.active) |=> (state_ff == ST_IDLE))
      else $error("Step without an active circle started an emission run.");

endmodule

@@ src/crast_datapath.sv @@
// ----------------------------------------------------------------------------
// Circle rasteriser datapath
// Holds the circle state, updates the decision and forms the symmetric points.
// ----------------------------------------------------------------------------
module crast_datapath
   import crast_pkg::*;
   #(
   parameter int RADIUS_BITS = RADIUS_BITS_DEFAULT
   )
   (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [CENTER_W-1:0]       req_center_x,
   input  logic [CENTER_W-1:0]       req_center_y,
   input  logic [RADIUS_W-1:0]       req_radius,
   input  ctrl_cmd_type              cmd,
   output ctrl_status_type           status,
   output logic signed [COORD_W-1:0] point_x,
   output logic signed [COORD_W-1:0] point_y,
   output logic                      last,
   output logic                      done_res
   );

   localparam int RB = RADIUS_BITS;
   localparam int DW = RADIUS_BITS + 4;
   localparam logic [POINT_W-1:0] LAST_POINT = POINT_W'(POINTS - 1);

   logic [CENTER_W-1:0]  center_x_ff, center_x_in;
   logic [CENTER_W-1:0]  center_y_ff, center_y_in;
   logic [RB-1:0]        offset_x_ff, offset_x_in;
   logic [RB-1:0]        offset_y_ff, offset_y_in;
   logic signed [DW-1:0] decision_ff, decision_in;
   logic                 active_ff, active_in;
   logic                 final_ff, final_in;
   logic [POINT_W-1:0]   point_ff, point_in;

   logic [RB+RADIUS_W-1:0] radius_wide;
   logic [RB-1:0]          radius_r;
   logic signed [DW-1:0]   dec_start;
   logic [RB-1:0]          x_next;
   logic [RB-1:0]          y_next;
   logic signed [RB:0]     diff;
   logic signed [DW-1:0]   dec_step;
   logic [COORD_W+RB-1:0]  a_wide;
   logic [COORD_W+RB-1:0]  b_wide;
   logic [COORD_W-1:0]     a_c;
   logic [COORD_W-1:0]     b_c;
   logic [COORD_W-1:0]     cx_c;
   logic [COORD_W-1:0]     cy_c;

   assign radius_wide = {{RB{1'b0}}, req_radius};
   assign radius_r    = radius_wide[RB-1:0];
   assign dec_start   = DW'(DEC_INIT) - $signed({3'b000, radius_r, 1'b0});

   assign x_next = offset_x_ff + RB'(1);
   assign y_next = decision_ff[DW-1] ? offset_y_ff : offset_y_ff - RB'(1);
   assign diff   = $signed({1'b0, x_next}) - $signed({1'b0, y_next});

   always_comb begin
      if (decision_ff[DW-1]) begin
         dec_step = decision_ff + $signed({2'b00, x_next, 2'b00}) + DW'(DEC_INC_KEEP);
      end else begin
         dec_step = decision_ff + $signed({diff[RB], diff, 2'b00}) + DW'(DEC_INC_DIAG);
      end
   end

   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      decision_in = decision_ff;
      active_in   = active_ff;
      final_in    = final_ff;
      point_in    = point_ff;
      if (cmd.next_point) begin
         point_in = point_ff + POINT_W'(1);
      end
      if (cmd.load_start) begin
         center_x_in = req_center_x;
         center_y_in = req_center_y;
         offset_x_in = '0;
         offset_y_in = radius_r;
         decision_in = dec_start;
         final_in    = (radius_r == '0);
         active_in   = (radius_r != '0);
         point_in    = '0;
      end else if (cmd.load_step) begin
         offset_x_in = x_next;
         offset_y_in = y_next;
         decision_in = dec_step;
         final_in    = !(x_next < y_next);
         active_in   = (x_next < y_next);
         point_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         decision_ff <= '0;
         active_ff   <= 1'b0;
         final_ff    <= 1'b0;
         point_ff    <= '0;
      end else begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         offset_x_ff <= offset_x_in;
         offset_y_ff <= offset_y_in;
         decision_ff <= decision_in;
         active_ff   <= active_in;
         final_ff    <= final_in;
         point_ff    <= point_in;
      end
   end

   // The upper four points swap the roles of the two offsets.
   assign a_wide = point_ff[2] ? {{COORD_W{1'b0}}, offset_y_ff}
                               : {{COORD_W{1'b0}}, offset_x_ff};
   assign b_wide = point_ff[2] ? {{COORD_W{1'b0}}, offset_x_ff}
                               : {{COORD_W{1'b0}}, offset_y_ff};
   assign a_c    = a_wide[COORD_W-1:0];
   assign b_c    = b_wide[COORD_W-1:0];
   assign cx_c   = {{(COORD_W-CENTER_W){1'b0}}, center_x_ff};
   assign cy_c   = {{(COORD_W-CENTER_W){1'b0}}, center_y_ff};

   assign point_x  = $signed(point_ff[0] ? cx_c - a_c : cx_c + a_c);
   assign point_y  = $signed(point_ff[1] ? cy_c - b_c : cy_c + b_c);
   assign last     = (point_ff == LAST_POINT);
   assign done_res = final_ff;

   assign status.active     = active_ff;
   assign status.point_last = (point_ff == LAST_POINT);

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.load_start |=> (point_ff == '0) && (offset_x_ff == '0))
      else $error("Start item did not clear the offset and point index.");

   a_active_order: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (offset_x_ff < offset_y_ff))
      else $error("Circle active although x is no longer below y.");

endmodule

@@ src/circle_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// Circle rasteriser
// Midpoint circle generator emitting eight symmetric points per position.
// ----------------------------------------------------------------------------
// A start item latches the centre and radius and emits the eight symmetric
// points of the first position; each step item advances one position and
// emits its eight points, with done_res set on the points of the final step.
// Points leave one per cycle from the point counter while rsp_bus.ready is
// held high, and the next item is taken in the cycle in which the eighth
// point of the current item is taken. A step with no circle in progress is
// taken and emits nothing.
module circle_rasterizer_unit
   import crast_pkg::*;
   #(
   parameter int RADIUS_BITS = RADIUS_BITS_DEFAULT
   )
   (
   input  logic     clock,
   input  logic     reset,
   crast_req_if.sink   req_bus,
   crast_rsp_if.source rsp_bus
   );

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   crast_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .req_ready  (req_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .status     (status),
      .cmd        (cmd)
   );

   crast_datapath #(
      .RADIUS_BITS (RADIUS_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_center_x (req_bus.center_x),
      .req_center_y (req_bus.center_y),
      .req_radius   (req_bus.radius),
      .cmd          (cmd),
      .status       (status),
      .point_x      (rsp_bus.point_x),
      .point_y      (rsp_bus.point_y),
      .last         (rsp_bus.last),
      .done_res     (rsp_bus.done_res)
   );

endmodule
